// ----- hdl/bitmap_page_run_allocator_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Bitmap page run allocator: assertion macros
// Shared macros for the concurrent checks on the allocator's ports.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_RUN_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_PAGE_RUN_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define BPRA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define BPRA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/bpra_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap page run allocator: package
// Sizes, codes and controller/datapath bundles shared by the allocator files.
// ----------------------------------------------------------------------------
`default_nettype none

package bpra_pkg;

    localparam int PAGES      = 1024;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PAGE_W     = $clog2(PAGES);
    localparam int RUN_W      = PAGE_W + 1;
    localparam int WORD_W     = 8;
    localparam int SUB_W      = $clog2(WORD_W);
    localparam int NWORDS     = PAGES / WORD_W;
    localparam int IDX_W      = $clog2(NWORDS);
    localparam int BYTE_W     = 23;
    localparam int ADDR_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int CNT_W      = BYTE_W - PAGE_SHIFT + 1;
    localparam int FPG_W      = ADDR_W - PAGE_SHIFT;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NOT_ALLOC = 2'd2
    } t_status;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_type;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_CHECK,
        S_UPDATE,
        S_RESP
    } t_state;

    typedef enum logic [1:0] {
        OP_SCAN,
        OP_CHECK,
        OP_UPDATE
    } t_op;

    typedef struct packed {
        logic    load;
        logic    start_scan;
        logic    start_check;
        logic    start_update;
        logic    upd_set;
        logic    set_status;
        t_status status;
        logic    push;
    } t_dp_cmd;

    typedef struct packed {
        logic is_free;
        logic alloc_bad;
        logic free_empty;
        logic free_out;
        logic done;
        logic hit;
        logic fail;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- hdl/bpra_if.sv -----
// ----------------------------------------------------------------------------
// Bitmap page run allocator: channel interfaces
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpra_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [bpra_pkg::BYTE_W-1:0]   byte_count;
    logic [bpra_pkg::ADDR_W-1:0]   address;

    modport source (output valid, req_type, byte_count, address, input ready);
    modport sink   (input valid, req_type, byte_count, address, output ready);
endinterface

interface bpra_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bpra_pkg::STATUS_W-1:0] status;
    logic [bpra_pkg::ADDR_W-1:0]   start_address;

    modport source (output valid, status, start_address, input ready);
    modport sink   (input valid, status, start_address, output ready);
endinterface

`default_nettype wire

// ----- hdl/bitmap_page_run_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// Bitmap page run allocator
// First-fit page run allocation and freeing over a one-bit-per-page map.
// ----------------------------------------------------------------------------
// Requests arrive on i_req (valid/ready): an allocate takes a byte count, a
// free takes a byte count and a start address. Every request produces one
// transaction on o_rsp with a status and, for a successful allocate, the
// run's start address.
// The map sits in a RAM of 8-bit rows and is read one row per cycle through
// its single read port. An allocate scans from row 0 until the first fitting
// run is found (at most PAGES/8 rows), then runs a write pass over the rows
// of the run. A free runs a check pass over its rows and, if every page is
// in use, a write pass over the same rows. Every request also goes through
// decode and hand-off; one that is rejected by its size alone makes no map
// pass.
// One request is in service at a time; i_req.ready is high only while idle.
// Reset clears the per-row valid flags, so the map reads as page 0 used and
// all other pages free at once, without a clearing pass.
// A stalled receiver holds the result in the output register; the next request
// is still taken and processed, and then waits for that register to empty.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_run_allocator_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bpra_req_if.sink   i_req,
    bpra_rsp_if.source o_rsp
);
    import bpra_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    bpra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bpra_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_req_type          (i_req.req_type),
        .i_byte_count        (i_req.byte_count),
        .i_address           (i_req.address),
        .o_rsp_valid         (o_rsp.valid),
        .i_rsp_ready         (o_rsp.ready),
        .o_rsp_status        (o_rsp.status),
        .o_rsp_start_address (o_rsp.start_address),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat)
    );

endmodule

`default_nettype wire

// ----- hdl/bpra_ram.sv -----
// ----------------------------------------------------------------------------
// Bitmap page run allocator: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bpra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/bpra_ctrl.sv -----
// ----------------------------------------------------------------------------
// Bitmap page run allocator: controller
// Sequences request intake, map passes and the response hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bpra_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire bpra_pkg::t_dp_stat i_stat,
    output bpra_pkg::t_dp_cmd       o_cmd
);
    import bpra_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_stat.is_free) begin
                    if (i_stat.alloc_bad) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_NO_SPACE;
                        n_state          = S_RESP;
                    end else begin
                        o_cmd.start_scan = 1'b1;
                        n_state          = S_SCAN;
                    end
                end else if (i_stat.free_empty) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_OK;
                    n_state          = S_RESP;
                end else if (i_stat.free_out) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NOT_ALLOC;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.start_check = 1'b1;
                    n_state           = S_CHECK;
                end
            end
            S_SCAN: begin
                if (i_stat.done) begin
                    if (i_stat.hit) begin
                        o_cmd.start_update = 1'b1;
                        o_cmd.upd_set      = 1'b1;
                        n_state            = S_UPDATE;
                    end else begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_NO_SPACE;
                        n_state          = S_RESP;
                    end
                end
            end
            S_CHECK: begin
                if (i_stat.done) begin
                    if (i_stat.fail) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_NOT_ALLOC;
                        n_state          = S_RESP;
                    end else begin
                        o_cmd.start_update = 1'b1;
                        n_state            = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                if (i_stat.done) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_OK;
                    n_state          = S_RESP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/bpra_dpath.sv -----
// ----------------------------------------------------------------------------
// Bitmap page run allocator: datapath
// Request registers, page map RAM, word-per-cycle scan and update passes,
// and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpra_dpath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_req_type,
    input  wire logic [bpra_pkg::BYTE_W-1:0]     i_byte_count,
    input  wire logic [bpra_pkg::ADDR_W-1:0]     i_address,
    output logic                                 o_rsp_valid,
    input  wire logic                            i_rsp_ready,
    output logic      [bpra_pkg::STATUS_W-1:0]   o_rsp_status,
    output logic      [bpra_pkg::ADDR_W-1:0]     o_rsp_start_address,
    input  wire bpra_pkg::t_dp_cmd               i_cmd,
    output bpra_pkg::t_dp_stat                   o_stat
);
    import bpra_pkg::*;

    // Request registers.
    t_req_type          r_kind;
    logic [CNT_W-1:0]   r_cnt;
    logic [FPG_W-1:0]   r_first;
    logic [PAGE_W-1:0]  r_lo;

    // Pass engine.
    t_op                r_op;
    logic               r_busy;
    logic [IDX_W-1:0]   r_rd_idx;
    logic [IDX_W-1:0]   r_end_idx;
    logic               r_q_vld;
    logic [IDX_W-1:0]   r_q_idx;
    logic               r_q_last;
    logic               r_q_rowvld;
    logic               r_upd_set;
    logic [NWORDS-1:0]  r_row_vld;
    logic               r_done;
    logic               r_hit;
    logic               r_fail;
    logic [RUN_W-1:0]   r_run;
    logic [PAGE_W-1:0]  r_start;

    // Response.
    t_status            r_res_status;
    logic               r_out_vld;
    t_status            r_out_status;
    logic [ADDR_W-1:0]  r_out_addr;

    logic [BYTE_W:0]    w_bytes_up;
    logic [FPG_W:0]     w_free_end;
    logic [PAGE_W-1:0]  w_hi;
    logic [WORD_W-1:0]  w_mem_q;
    logic [WORD_W-1:0]  w_word;
    logic [WORD_W-1:0]  w_mask;
    logic [WORD_W-1:0]  w_wdata;
    logic               w_we;
    logic               w_fail;
    logic               w_hit;
    logic [RUN_W-1:0]   w_run;
    logic [PAGE_W-1:0]  w_start;
    logic [PAGE_W-1:0]  w_hstart;
    logic               w_stop;
    logic               w_out_free;

    assign w_bytes_up = {1'b0, i_byte_count} + (BYTE_W + 1)'(PAGE_BYTES - 1);
    assign w_free_end = {1'b0, r_first} + (FPG_W + 1)'(r_cnt);
    assign w_hi       = r_lo + PAGE_W'(r_cnt) - PAGE_W'(1);

    bpra_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NWORDS)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_q_idx),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (w_mem_q)
    );

    // A row never written holds its reset pattern: page 0 used, all else free.
    assign w_word = r_q_rowvld ? w_mem_q :
                    ((r_q_idx == '0) ? WORD_W'(1) : '0);

    always_comb begin
        logic [PAGE_W-1:0] p;
        w_mask = '0;
        for (int i = 0; i < WORD_W; i++) begin
            p         = {r_q_idx, SUB_W'(i)};
            w_mask[i] = (p >= r_lo) && (p <= w_hi);
        end
    end

    always_comb begin
        logic [PAGE_W-1:0] p;
        w_run    = r_run;
        w_start  = r_start;
        w_hit    = 1'b0;
        w_hstart = r_start;
        for (int i = 0; i < WORD_W; i++) begin
            p = {r_q_idx, SUB_W'(i)};
            if (w_word[i]) begin
                w_run = '0;
            end else begin
                if (w_run == '0) begin
                    w_start = p;
                end
                w_run = w_run + RUN_W'(1);
                if (!w_hit && (32'(w_run) == 32'(r_cnt))) begin
                    w_hit    = 1'b1;
                    w_hstart = w_start;
                end
            end
        end
    end

    assign w_fail  = |(w_mask & ~w_word);
    assign w_wdata = r_upd_set ? (w_word | w_mask) : (w_word & ~w_mask);
    assign w_we    = r_q_vld && (r_op == OP_UPDATE);
    assign w_stop  = r_q_vld && (r_q_last || ((r_op == OP_SCAN) && w_hit) ||
                                 ((r_op == OP_CHECK) && w_fail));

    assign w_out_free = !r_out_vld || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_q_vld   <= 1'b0;
            r_done    <= 1'b0;
            r_row_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_done <= w_stop;
            if (r_busy) begin
                r_q_vld <= 1'b1;
                if (r_rd_idx == r_end_idx) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_q_vld <= 1'b0;
            end
            if (w_stop) begin
                r_busy  <= 1'b0;
                r_q_vld <= 1'b0;
            end
            if (i_cmd.start_scan || i_cmd.start_check || i_cmd.start_update) begin
                r_busy <= 1'b1;
            end
            if (w_we) begin
                r_row_vld[r_q_idx] <= 1'b1;
            end
            if (i_cmd.push) begin
                r_out_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= t_req_type'(i_req_type);
            r_cnt   <= w_bytes_up[BYTE_W:PAGE_SHIFT];
            r_first <= i_address[ADDR_W-1:PAGE_SHIFT];
            r_lo    <= i_address[PAGE_SHIFT +: PAGE_W];
        end
        if (r_busy) begin
            r_q_idx    <= r_rd_idx;
            r_q_last   <= (r_rd_idx == r_end_idx);
            r_q_rowvld <= r_row_vld[r_rd_idx];
            r_rd_idx   <= r_rd_idx + IDX_W'(1);
        end
        if (i_cmd.start_scan) begin
            r_op      <= OP_SCAN;
            r_rd_idx  <= '0;
            r_end_idx <= IDX_W'(NWORDS - 1);
            r_run     <= '0;
            r_start   <= '0;
        end
        if (i_cmd.start_check) begin
            r_op      <= OP_CHECK;
            r_rd_idx  <= r_lo[PAGE_W-1:SUB_W];
            r_end_idx <= w_hi[PAGE_W-1:SUB_W];
        end
        if (i_cmd.start_update) begin
            r_op      <= OP_UPDATE;
            r_rd_idx  <= r_lo[PAGE_W-1:SUB_W];
            r_end_idx <= w_hi[PAGE_W-1:SUB_W];
            r_upd_set <= i_cmd.upd_set;
        end
        if (r_q_vld && (r_op == OP_SCAN)) begin
            r_run   <= w_run;
            r_start <= w_start;
            if (w_hit) begin
                r_lo <= w_hstart;
            end
        end
        if (w_stop) begin
            r_hit  <= (r_op == OP_SCAN) && w_hit;
            r_fail <= (r_op == OP_CHECK) && w_fail;
        end
        if (i_cmd.set_status) begin
            r_res_status <= i_cmd.status;
        end
        if (i_cmd.push) begin
            r_out_status <= r_res_status;
            if ((r_res_status == ST_OK) && (r_kind == REQ_ALLOC)) begin
                r_out_addr <= ADDR_W'({r_lo, PAGE_SHIFT'(0)});
            end else begin
                r_out_addr <= '0;
            end
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.is_free    = (r_kind == REQ_FREE);
        o_stat.alloc_bad  = (r_cnt == '0) || (32'(r_cnt) > 32'(PAGES));
        o_stat.free_empty = (r_cnt == '0);
        o_stat.free_out   = (w_free_end > (FPG_W + 1)'(PAGES));
        o_stat.done       = r_done;
        o_stat.hit        = r_hit;
        o_stat.fail       = r_fail;
        o_stat.out_free   = w_out_free;
    end

    assign o_rsp_valid         = r_out_vld;
    assign o_rsp_status        = r_out_status;
    assign o_rsp_start_address = r_out_addr;

endmodule

`default_nettype wire

// ----- hdl/bpra_checker.sv -----
// ----------------------------------------------------------------------------
// Bitmap page run allocator: port checker
// Concurrent checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_page_run_allocator_unit_defines.svh"

module bpra_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_rsp_valid,
    input wire logic                            i_rsp_ready,
    input wire logic [bpra_pkg::STATUS_W-1:0]   i_rsp_status,
    input wire logic [bpra_pkg::ADDR_W-1:0]     i_rsp_start_address
);
    import bpra_pkg::*;

    `BPRA_ASSERT_NXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_start_address), "Stalled response changed.")
    `BPRA_ASSERT_IMP(a_status_code, i_rsp_valid, (i_rsp_status == ST_OK) || (i_rsp_status == ST_NO_SPACE) || (i_rsp_status == ST_NOT_ALLOC), "Unknown status code.")
    `BPRA_ASSERT_IMP(a_addr_zero, i_rsp_valid && (i_rsp_status != ST_OK), i_rsp_start_address == '0, "Failed request returned an address.")
    `BPRA_ASSERT_IMP(a_addr_align, i_rsp_valid, i_rsp_start_address[PAGE_SHIFT-1:0] == '0, "Start address is not page aligned.")

endmodule

bind bitmap_page_run_allocator_unit bpra_checker u_bpra_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_status        (o_rsp.status),
    .i_rsp_start_address (o_rsp.start_address)
);

`default_nettype wire
